### rtl/next_fit_page_slot_allocator_top_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef NEXT_FIT_PAGE_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define NEXT_FIT_PAGE_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside of reset.
`define NFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An antecedent that must be followed by a consequent in the next cycle.
`define NFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/nfpa_pkg.sv
// Types and constants of the next-fit page slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package nfpa_pkg;

  localparam int NUM_SLOTS_DEF = 1024;
  localparam int WORD_W        = 32;
  localparam int BIT_W         = 5;
  localparam int PAGE_SHIFT    = 12;
  localparam int PAGE_NUM_W    = 20;
  localparam int ADDR_W        = 32;
  localparam int STATUS_W      = 2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NONE_FREE   = 2'd1,
    STAT_INVALID     = 2'd2,
    STAT_DOUBLE_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_ASCAN  = 2'd2,
    ST_FCHECK = 2'd3
  } state_t;

endpackage

`default_nettype wire

### rtl/next_fit_page_slot_allocator_top.sv
// Next-fit page slot allocator: bitmap memory, scan sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

`include "next_fit_page_slot_allocator_top_assert.svh"

// The block hands out and takes back 4 KiB page slots of a window of NUM_SLOTS pages.
// An item is taken at a clock edge where start is high and busy is low. Mode 0 asks
// for a slot; mode 1 frees the page that holds address. Each item gives exactly one
// result, shown on status and slot_addr for one cycle while done is high. The
// receiver cannot stall, so results are never held back.
// The used/free bitmap lives in a memory of 32-bit words with one read and one write
// port. An allocate reads one word per cycle through a find-first-free unit, starting
// at the word of the slot after the last one chosen and ending with a second look at
// that word. A free reads the word of its page and, if the bit is set, writes it back
// cleared; an address outside the window is answered in the cycle after acceptance.
// Busy drops in the cycle that shows done, so the next item can be taken there.
// The window base page is written on the cfg channel, which is always ready; it is
// to be written only while the block is idle.
// After reset the block clears every bitmap word, one word per cycle, with busy high;
// configuration writes are taken during that pass.
module next_fit_page_slot_allocator_top #(
  parameter int NUM_SLOTS = nfpa_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              mode,
  input  wire logic [nfpa_pkg::ADDR_W-1:0]       address,
  output logic                                   done,
  output logic [nfpa_pkg::STATUS_W-1:0]          status,
  output logic [nfpa_pkg::ADDR_W-1:0]            slot_addr,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nfpa_pkg::PAGE_NUM_W-1:0]   cfg_data
);
  import nfpa_pkg::*;

  localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int SX        = WORD_AW + BIT_W;
  localparam int CW        = $clog2(NUM_WORDS + 2);
  localparam int TAIL_BITS = NUM_SLOTS - (NUM_WORDS - 1) * WORD_W;

  localparam logic [SLOT_W-1:0]     LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [WORD_AW-1:0]    LAST_WORD  = WORD_AW'(NUM_WORDS - 1);
  localparam logic [CW-1:0]         ISSUE_MAX  = CW'(NUM_WORDS + 1);
  localparam logic [PAGE_NUM_W-1:0] SLOTS_PG   = PAGE_NUM_W'(NUM_SLOTS);
  localparam logic [WORD_W-1:0]     TAIL_MASK  = WORD_W'((64'd1 << TAIL_BITS) - 64'd1);

  // Bitmap memory: one bit per slot, set means used.
  logic [WORD_W-1:0] bitmap [NUM_WORDS];
  logic [WORD_W-1:0] rd_data;
  logic              rd_en;
  logic [WORD_AW-1:0] rd_addr;
  logic              wr_en;
  logic [WORD_AW-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  // Control and payload registers.
  state_t              state, state_next;
  logic [WORD_AW-1:0]  clr_addr, clr_addr_next;
  logic [WORD_AW-1:0]  scan_word, scan_word_next;
  logic [CW-1:0]       issued, issued_next;
  logic                chk_valid;
  logic [WORD_AW-1:0]  chk_word;
  logic                chk_first, chk_first_next;
  logic                chk_last, chk_last_next;
  logic [BIT_W-1:0]    start_bit, start_bit_next;
  logic [BIT_W-1:0]    free_bit, free_bit_next;
  logic [SLOT_W-1:0]   last_slot, last_slot_next;
  logic [PAGE_NUM_W-1:0] win_base;
  logic                done_next;
  status_t             status_reg, status_next;
  logic [ADDR_W-1:0]   slot_addr_next;

  // Combinational helpers.
  logic [SLOT_W-1:0]     start_slot;
  logic [SX-1:0]         start_ext;
  logic [PAGE_NUM_W-1:0] page_off;
  logic [SX-1:0]         off_ext;
  logic [WORD_W-1:0]     pos_mask;
  logic [WORD_W-1:0]     range_mask;
  logic [WORD_W-1:0]     free_vec;
  logic [BIT_W-1:0]      free_idx;
  logic [SLOT_W-1:0]     found_slot;
  logic [PAGE_NUM_W-1:0] found_page;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign status    = status_reg;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= bitmap[rd_addr];
    end
  end

  // Next-fit start point and the window offset of a page to free.
  assign start_slot = (last_slot == LAST_SLOT) ? '0 : last_slot + 1'b1;
  assign start_ext  = SX'(start_slot);
  assign page_off   = address[ADDR_W-1:PAGE_SHIFT] - win_base;
  assign off_ext    = SX'(page_off[SLOT_W-1:0]);

  // Find-first-free over the word that came back from the memory. The first look
  // at the starting word covers the bits from the start bit up, the final look the
  // bits below it; slots past the end of the window always count as used.
  always_comb begin
    pos_mask = '1;
    if (chk_first) begin
      pos_mask = {WORD_W{1'b1}} << start_bit;
    end else if (chk_last) begin
      pos_mask = ~({WORD_W{1'b1}} << start_bit);
    end
    range_mask = (chk_word == LAST_WORD) ? TAIL_MASK : '1;
    free_vec   = ~rd_data & pos_mask & range_mask;
    free_idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = BIT_W'(i);
      end
    end
  end

  assign found_slot = SLOT_W'({chk_word, free_idx});
  assign found_page = win_base + PAGE_NUM_W'(found_slot);

  // Sequencer: next state, memory control and result.
  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    scan_word_next    = scan_word;
    issued_next       = issued;
    chk_first_next    = chk_first;
    chk_last_next     = chk_last;
    start_bit_next    = start_bit;
    free_bit_next     = free_bit;
    last_slot_next    = last_slot;
    done_next         = 1'b0;
    status_next       = status_reg;
    slot_addr_next    = slot_addr;
    rd_en             = 1'b0;
    rd_addr           = scan_word;
    wr_en             = 1'b0;
    wr_addr           = chk_word;
    wr_data           = rd_data;

    case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_ALLOC) begin
            rd_en          = 1'b1;
            rd_addr        = start_ext[SX-1:BIT_W];
            scan_word_next = (start_ext[SX-1:BIT_W] == LAST_WORD) ? '0
                             : start_ext[SX-1:BIT_W] + 1'b1;
            issued_next    = CW'(1);
            chk_first_next = 1'b1;
            chk_last_next  = 1'b0;
            start_bit_next = start_ext[BIT_W-1:0];
            state_next     = ST_ASCAN;
          end else if (page_off >= SLOTS_PG) begin
            done_next         = 1'b1;
            status_next       = STAT_INVALID;
            slot_addr_next    = '0;
          end else begin
            rd_en          = 1'b1;
            rd_addr        = off_ext[SX-1:BIT_W];
            free_bit_next  = off_ext[BIT_W-1:0];
            chk_first_next = 1'b0;
            chk_last_next  = 1'b0;
            state_next     = ST_FCHECK;
          end
        end
      end

      ST_ASCAN: begin
        if (chk_valid && (free_vec != '0)) begin
          wr_en             = 1'b1;
          wr_addr           = chk_word;
          wr_data           = rd_data | (WORD_W'(1) << free_idx);
          last_slot_next    = found_slot;
          done_next         = 1'b1;
          status_next       = STAT_OK;
          slot_addr_next    = {found_page, {PAGE_SHIFT{1'b0}}};
          state_next        = ST_IDLE;
        end else if (chk_valid && chk_last) begin
          done_next         = 1'b1;
          status_next       = STAT_NONE_FREE;
          slot_addr_next    = '0;
          state_next        = ST_IDLE;
        end else if (issued != ISSUE_MAX) begin
          rd_en          = 1'b1;
          rd_addr        = scan_word;
          scan_word_next = (scan_word == LAST_WORD) ? '0 : scan_word + 1'b1;
          issued_next    = issued + 1'b1;
          chk_first_next = 1'b0;
          chk_last_next  = ((issued + 1'b1) == ISSUE_MAX);
        end
      end

      ST_FCHECK: begin
        done_next         = 1'b1;
        slot_addr_next    = '0;
        state_next        = ST_IDLE;
        if (rd_data[free_bit]) begin
          wr_en       = 1'b1;
          wr_addr     = chk_word;
          wr_data     = rd_data & ~(WORD_W'(1) << free_bit);
          status_next = STAT_OK;
        end else begin
          status_next = STAT_DOUBLE_FREE;
        end
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_addr         <= '0;
      issued           <= '0;
      chk_valid        <= 1'b0;
      chk_first        <= 1'b0;
      chk_last         <= 1'b0;
      last_slot        <= LAST_SLOT;
      win_base         <= '0;
      done             <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      issued    <= issued_next;
      chk_valid <= rd_en;
      chk_first <= chk_first_next;
      chk_last  <= chk_last_next;
      last_slot <= last_slot_next;
      done      <= done_next;
      if (cfg_valid && cfg_ready) begin
        win_base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_word    <= scan_word_next;
    start_bit    <= start_bit_next;
    free_bit     <= free_bit_next;
    status_reg   <= status_next;
    slot_addr    <= slot_addr_next;
    if (rd_en) begin
      chk_word <= rd_addr;
    end
  end

  // A result is only shown once the block has gone back to idle.
  `NFPA_ASSERT(a_done_idle, done |-> !busy, "result strobe while block is busy")
  // An accepted item either keeps the block busy or is answered at once.
  `NFPA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted item dropped")
  // Every status but ok carries a zero page address.
  `NFPA_ASSERT(a_zero_addr, (done && (status_reg != STAT_OK)) |-> (slot_addr == '0),
               "nonzero page address on a failed request")
  // Read data is only checked while an allocate or a free is in progress.
  `NFPA_ASSERT(a_chk_state, chk_valid |-> ((state == ST_ASCAN) || (state == ST_FCHECK)),
               "word check outside of a request")
  // The scan never reads more than one full turn plus the starting word again.
  `NFPA_ASSERT(a_issue_bound, issued <= ISSUE_MAX, "bitmap scan ran past one turn")

endmodule

`default_nettype wire
